// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the strided slice parameter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define SSAP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("strided slice check failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define SSAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("strided slice check failed");

`endif

// ----- hw/rtl/ssap_pkg.sv -----
// Package with the types, widths and codes of the strided slice parameter block.
`timescale 1ns / 1ps

package ssap_pkg;

   localparam int MAX_AXES      = 8;
   localparam int AXIS_WIDTH    = 3;
   localparam int MASK_WIDTH    = 8;
   localparam int LENGTH_WIDTH  = 31;
   localparam int INDEX_WIDTH   = 32;
   localparam int CALC_WIDTH    = 34;
   localparam int REM_WIDTH     = 32;
   localparam int STATUS_WIDTH  = 2;
   localparam int DIV_STEPS     = LENGTH_WIDTH;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_STRIDE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OPPOSED     = 2'd2;

   typedef logic signed [CALC_WIDTH-1:0] calc_type;

   typedef struct packed {
      logic [AXIS_WIDTH-1:0]          axis_number;
      logic [LENGTH_WIDTH-1:0]        axis_length;
      logic signed [INDEX_WIDTH-1:0]  slice_start;
      logic signed [INDEX_WIDTH-1:0]  slice_end;
      logic signed [INDEX_WIDTH-1:0]  stride_value;
      logic                           infer_unknown;
   } req_payload_type;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0]        out_length;
      logic signed [INDEX_WIDTH-1:0]  norm_start;
      logic signed [INDEX_WIDTH-1:0]  norm_end;
      logic signed [INDEX_WIDTH-1:0]  norm_stride;
      logic                           is_decreased;
      logic [STATUS_WIDTH-1:0]        status;
   } rsp_payload_type;

   // A classified request as it waits between the front and the back.
   typedef struct packed {
      logic                           dec;
      logic                           zero;
      logic                           neg;
      calc_type                       lo_bound;
      calc_type                       hi_bound;
      logic [LENGTH_WIDTH-1:0]        axis_length;
      logic signed [INDEX_WIDTH-1:0]  stride;
      logic signed [INDEX_WIDTH-1:0]  norm_start;
      logic signed [INDEX_WIDTH-1:0]  norm_end;
   } cls_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hw/rtl/strided_slice_axis_params.sv -----
// Top level of the strided slice axis parameter block.
`timescale 1ns / 1ps
// Usage:
//   Each request on the req_ channel describes one tensor axis (length, start,
//   end, stride, axis number, infer flag). Each request yields exactly one
//   response on the rsp_ channel with the element count, the normalized start,
//   end and stride, the decreased flag and a status code, in request order.
//   A channel moves a request on a rising edge where valid is high and stall
//   is low. The csr_ port writes decrease_mask on any edge with the write
//   enable high; write it only while no requests are in flight.
// Pipeline and throughput:
//   A request is taken into the queue on the accepting edge, then passes the
//   range check register, 31 one-bit steps of the restoring divider and the
//   output register. The divider pipeline takes a new request every cycle
//   while rsp_stall does not hold a valid response, so the sustained rate is
//   one request per cycle.
// Reset:
//   Reset clears the mask, the queue and all pipeline valid bits.
// Backpressure:
//   While rsp_stall holds a valid response, the back pipeline freezes; the
//   four-entry queue keeps taking requests until it fills, then req_stall rises.

module strided_slice_axis_params import ssap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [MASK_WIDTH-1:0] csr_write_data
);

   logic [MASK_WIDTH-1:0] decrease_mask_ff;
   cls_entry_type         front_entry;
   cls_entry_type         queue_head;
   queue_status_type      q_status;
   logic                  push;
   logic                  pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrease_mask_ff <= '0;
      end else if (csr_write_enable) begin
         decrease_mask_ff <= csr_write_data;
      end
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   ssap_front u_front (
      .req_payload   (req_payload),
      .decrease_mask (decrease_mask_ff),
      .entry         (front_entry)
   );

   ssap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .pop       (pop),
      .head      (queue_head),
      .status    (q_status)
   );

   ssap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (queue_head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- hw/rtl/ssap_front.sv -----
// Front part: classifies a request and works out its clamped bounds and indices.
`timescale 1ns / 1ps

module ssap_front import ssap_pkg::*; (
   input  req_payload_type          req_payload,
   input  logic [MASK_WIDTH-1:0]    decrease_mask,
   output cls_entry_type            entry
);

   calc_type s_x, e_x, d_x, a_x, b_x, ns_x, ne_x;
   logic     neg, dec;

   always_comb begin
      s_x = {{(CALC_WIDTH-INDEX_WIDTH){req_payload.slice_start[INDEX_WIDTH-1]}},
             req_payload.slice_start};
      e_x = {{(CALC_WIDTH-INDEX_WIDTH){req_payload.slice_end[INDEX_WIDTH-1]}},
             req_payload.slice_end};
      d_x = {{(CALC_WIDTH-LENGTH_WIDTH){1'b0}}, req_payload.axis_length};
      neg = req_payload.stride_value[INDEX_WIDTH-1];

      dec = 1'b0;
      if (s_x == -1 && e_x == 0 && req_payload.infer_unknown &&
          int'(req_payload.axis_number) < MAX_AXES) begin
         dec = decrease_mask[req_payload.axis_number];
      end

      // Bounds used for the element count.
      if (s_x < 0) begin
         a_x = s_x + d_x;
         if (a_x < 0) begin
            a_x = '0;
         end
      end else begin
         a_x = s_x;
      end
      // An end of -1 with a negative stride means "run to the very front".
      if (e_x < 0 && !(e_x == -1 && neg)) begin
         b_x = e_x + d_x;
         if (b_x < 0) begin
            b_x = '0;
         end
      end else begin
         b_x = e_x;
      end
      if (neg) begin
         a_x = a_x + 1;
         b_x = b_x + 1;
      end

      // Indices for the slicing engine.
      if (neg) begin
         if (s_x < 0) begin
            ns_x = (s_x < -d_x) ? -d_x : s_x;
         end else begin
            ns_x = ((s_x < d_x - 1) ? s_x : d_x - 1) - d_x;
         end
         if (e_x < 0) begin
            ne_x = (e_x < -d_x - 1) ? -d_x - 1 : e_x;
         end else begin
            ne_x = e_x - d_x;
         end
      end else begin
         if (s_x < 0) begin
            ns_x = ((s_x < -d_x) ? -d_x : s_x) + d_x;
         end else begin
            ns_x = (s_x < d_x - 1) ? s_x : d_x - 1;
         end
         if (e_x < 0) begin
            ne_x = e_x + d_x;
         end else begin
            ne_x = (e_x < d_x) ? e_x : d_x;
         end
      end
      if (dec) begin
         ne_x = neg ? ns_x - 1 : ns_x + 1;
      end

      entry.dec         = dec;
      entry.zero        = (req_payload.stride_value == '0);
      entry.neg         = neg;
      entry.lo_bound    = a_x;
      entry.hi_bound    = b_x;
      entry.axis_length = req_payload.axis_length;
      entry.stride      = req_payload.stride_value;
      entry.norm_start  = ns_x[INDEX_WIDTH-1:0];
      entry.norm_end    = ne_x[INDEX_WIDTH-1:0];
   end

endmodule

// ----- hw/rtl/ssap_queue.sv -----
// Short request queue in flip-flops between the front and the back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssap_queue import ssap_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cls_entry_type    push_data,
   input  logic             pop,
   output cls_entry_type    head,
   output queue_status_type status
);

   cls_entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   `SSAP_ASSERT(q_count_bound, clock, reset, count_ff <= QCNT_WIDTH'(QUEUE_DEPTH))
   `SSAP_ASSERT_IMPL(q_pop_nonempty, clock, reset, pop, count_ff != '0)

endmodule

// ----- hw/rtl/ssap_back.sv -----
// Back part: range check, pipelined ceiling divide by the stride and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssap_back import ssap_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cls_entry_type    head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload
);

   typedef struct packed {
      logic [REM_WIDTH-1:0]           rem;
      logic [LENGTH_WIDTH-1:0]        num;
      logic [LENGTH_WIDTH-1:0]        quo;
      logic [REM_WIDTH-1:0]           divisor;
      logic                           active;
      logic                           dec;
      logic [STATUS_WIDTH-1:0]        status;
      logic signed [INDEX_WIDTH-1:0]  norm_start;
      logic signed [INDEX_WIDTH-1:0]  norm_end;
      logic signed [INDEX_WIDTH-1:0]  stride;
   } div_stage_type;

   div_stage_type   pipe_ff [DIV_STEPS+1];
   div_stage_type   pipe_in [DIV_STEPS+1];
   logic            valid_ff [DIV_STEPS+1];
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff;
   logic            advance;
   calc_type        left_x, right_x, d_x;
   logic            opposed;

   // One restoring division step: brings in the next numerator bit.
   function automatic div_stage_type div_step(input div_stage_type cur);
      div_stage_type        nxt;
      logic [REM_WIDTH-1:0] rem_sh;
      nxt    = cur;
      rem_sh = {cur.rem[REM_WIDTH-2:0], cur.num[LENGTH_WIDTH-1]};
      nxt.num = {cur.num[LENGTH_WIDTH-2:0], 1'b0};
      if (rem_sh >= cur.divisor) begin
         nxt.rem = rem_sh - cur.divisor;
         nxt.quo = {cur.quo[LENGTH_WIDTH-2:0], 1'b1};
      end else begin
         nxt.rem = rem_sh;
         nxt.quo = {cur.quo[LENGTH_WIDTH-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // The whole pipeline moves together whenever the result register can take a value.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   always_comb begin
      d_x     = {{(CALC_WIDTH-LENGTH_WIDTH){1'b0}}, head.axis_length};
      left_x  = (head.lo_bound < head.hi_bound) ? head.lo_bound : head.hi_bound;
      if (left_x < 0) begin
         left_x = '0;
      end
      right_x = (head.lo_bound > head.hi_bound) ? head.lo_bound : head.hi_bound;
      if (right_x > d_x) begin
         right_x = d_x;
      end
      opposed = head.neg ? (head.lo_bound < head.hi_bound) :
                           (head.lo_bound > head.hi_bound);

      pipe_in[0].rem        = '0;
      // ceil(n / step) is computed as floor((n - 1) / step) + 1.
      pipe_in[0].num        = LENGTH_WIDTH'(right_x - left_x - 1);
      pipe_in[0].quo        = '0;
      pipe_in[0].divisor    = head.neg ? REM_WIDTH'(-head.stride) : REM_WIDTH'(head.stride);
      pipe_in[0].dec        = head.dec;
      pipe_in[0].norm_start = head.norm_start;
      pipe_in[0].norm_end   = head.norm_end;
      pipe_in[0].stride     = head.stride;
      pipe_in[0].active     = 1'b0;
      if (head.dec) begin
         pipe_in[0].status = STATUS_OK;
      end else if (head.zero) begin
         pipe_in[0].status = STATUS_ZERO_STRIDE;
      end else if (opposed) begin
         pipe_in[0].status = STATUS_OPPOSED;
      end else begin
         pipe_in[0].status = STATUS_OK;
         pipe_in[0].active = (right_x > left_x);
      end

      for (int k = 1; k <= DIV_STEPS; k++) begin
         pipe_in[k] = div_step(pipe_ff[k-1]);
      end

      rsp_in.norm_start   = pipe_ff[DIV_STEPS].norm_start;
      rsp_in.norm_end     = pipe_ff[DIV_STEPS].norm_end;
      rsp_in.norm_stride  = pipe_ff[DIV_STEPS].stride;
      rsp_in.is_decreased = pipe_ff[DIV_STEPS].dec;
      rsp_in.status       = pipe_ff[DIV_STEPS].status;
      if (pipe_ff[DIV_STEPS].dec) begin
         rsp_in.out_length = LENGTH_WIDTH'(1);
      end else if (pipe_ff[DIV_STEPS].active) begin
         rsp_in.out_length = pipe_ff[DIV_STEPS].quo + 1'b1;
      end else begin
         rsp_in.out_length = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= pop;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SSAP_ASSERT_IMPL(bk_dec_len_one, clock, reset, rsp_valid_ff && rsp_ff.is_decreased, rsp_ff.out_length == LENGTH_WIDTH'(1) && rsp_ff.status == STATUS_OK)
   `SSAP_ASSERT_IMPL(bk_err_len_zero, clock, reset, rsp_valid_ff && rsp_ff.status != STATUS_OK, rsp_ff.out_length == '0)

endmodule

// ----- test/tb_strided_slice_axis_params.sv -----
// Self-checking testbench for the strided slice axis parameter block.
`timescale 1ns / 1ps

module tb_strided_slice_axis_params import ssap_pkg::*; ();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int TAIL_CYCLES   = 40;
   localparam int PHASE_ITEMS   = 400;
   localparam int HOLD_AT       = 500;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRINT_LIMIT   = 50;
   localparam int IDX_MIN       = 32'h8000_0000;
   localparam int IDX_MAX       = 32'h7fff_ffff;
   localparam logic [MASK_WIDTH-1:0] DIRECTED_MASK = 8'hA5;

   // Holds the predicted responses in request order and compares them.
   class SliceScoreboard;
      rsp_payload_type       expected_rsp[$];
      logic [MASK_WIDTH-1:0] mask;
      int                    mismatches;
      int                    checked;
      int                    dropped;
      int                    zero_strides;
      int                    opposed;

      function new();
         mask = '0;
         mismatches = 0;
         checked = 0;
         dropped = 0;
         zero_strides = 0;
         opposed = 0;
      endfunction

      function longint lmax(longint a, longint b);
         return (a > b) ? a : b;
      endfunction

      function longint lmin(longint a, longint b);
         return (a < b) ? a : b;
      endfunction

      function rsp_payload_type predict_axis(req_payload_type p);
         longint                  d, s, e, st, a, b, lo, hi, step, ns, ne, len;
         logic                    dec;
         logic [STATUS_WIDTH-1:0] stat;
         rsp_payload_type         r;
         d = longint'(p.axis_length);
         s = longint'($signed(p.slice_start));
         e = longint'($signed(p.slice_end));
         st = longint'($signed(p.stride_value));
         dec = 1'b0;
         len = 0;
         stat = STATUS_OK;
         if (s == -1 && e == 0 && p.infer_unknown && p.axis_number < MAX_AXES)
            dec = mask[p.axis_number];

         if (dec) begin
            len = 1;
         end else if (st == 0) begin
            stat = STATUS_ZERO_STRIDE;
         end else begin
            a = s;
            b = e;
            if (a < 0)
               a = lmax(a + d, 0);
            // An end of -1 with a negative stride means "run past the front".
            if (b < 0 && !(b == -1 && st < 0))
               b = lmax(b + d, 0);
            if (st < 0) begin
               a = a + 1;
               b = b + 1;
            end
            if ((st < 0 && a < b) || (st > 0 && a > b)) begin
               stat = STATUS_OPPOSED;
            end else begin
               lo = lmax(0, lmin(a, b));
               hi = lmin(d, lmax(a, b));
               step = (st < 0) ? -st : st;
               if (hi > lo)
                  len = (hi - lo + step - 1) / step;
            end
         end

         if (st < 0) begin
            ns = (s < 0) ? lmax(s, -d) : lmin(s, d - 1) - d;
            ne = (e < 0) ? lmax(e, -d - 1) : e - d;
         end else begin
            ns = (s < 0) ? lmax(s, -d) + d : lmin(s, d - 1);
            ne = (e < 0) ? e + d : lmin(e, d);
         end
         if (dec)
            ne = (st < 0) ? ns - 1 : ns + 1;

         r.out_length = len[LENGTH_WIDTH-1:0];
         r.norm_start = ns[INDEX_WIDTH-1:0];
         r.norm_end = ne[INDEX_WIDTH-1:0];
         r.norm_stride = st[INDEX_WIDTH-1:0];
         r.is_decreased = dec;
         r.status = stat;
         return r;
      endfunction

      // New predictions enter at the front; the oldest leaves from the back.
      function void note_request(req_payload_type p);
         expected_rsp.push_front(predict_axis(p));
      endfunction

      task report_mismatch(string what, longint want_v, longint got_v);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what,
                     want_v, got_v);
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with no request pending, out_length", 0,
                            got.out_length);
            return;
         end
         want = expected_rsp.pop_back();
         checked++;
         if (want.is_decreased)
            dropped++;
         if (want.status == STATUS_ZERO_STRIDE)
            zero_strides++;
         if (want.status == STATUS_OPPOSED)
            opposed++;
         if (got.out_length !== want.out_length)
            report_mismatch("out_length", want.out_length, got.out_length);
         if (got.norm_start !== want.norm_start)
            report_mismatch("norm_start", want.norm_start, got.norm_start);
         if (got.norm_end !== want.norm_end)
            report_mismatch("norm_end", want.norm_end, got.norm_end);
         if (got.norm_stride !== want.norm_stride)
            report_mismatch("norm_stride", want.norm_stride, got.norm_stride);
         if (got.is_decreased !== want.is_decreased)
            report_mismatch("is_decreased", want.is_decreased, got.is_decreased);
         if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_write_enable;
   logic [MASK_WIDTH-1:0] csr_write_data;

   SliceScoreboard sb = new();
   bit             idle_on;
   int             cycle_count = 0;
   int             input_stall_cycles = 0;
   int             mask_settings;

   strided_slice_axis_params uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Both handshakes are observed here, on the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_payload);
         if (req_valid && req_stall)
            input_stall_cycles <= input_stall_cycles + 1;
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_payload);
      end
   end

   // Response side: random stall bursts, plus one long hold-off that lets the
   // block fill up while requests keep coming.
   initial begin
      int   taken;
      int   hold_left;
      int   burst_left;
      bit   hold_done;
      logic next_stall;
      taken = 0;
      hold_left = 0;
      burst_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            taken++;
         if (!hold_done && taken == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            next_stall = 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 4);
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         @(negedge clock);
         rsp_stall <= next_stall;
      end
   end

   task automatic send_request(req_payload_type p);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_fields(int ax, int len, int s, int e, int st, bit inf);
      req_payload_type p;
      p.axis_number = ax[AXIS_WIDTH-1:0];
      p.axis_length = len[LENGTH_WIDTH-1:0];
      p.slice_start = s;
      p.slice_end = e;
      p.stride_value = st;
      p.infer_unknown = inf;
      send_request(p);
   endtask

   // Waits until every request has answered, then writes the mask.
   task automatic write_mask(logic [MASK_WIDTH-1:0] m);
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0)
         @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      sb.mask = m;
      mask_settings++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [INDEX_WIDTH-1:0] pick_index(logic [LENGTH_WIDTH-1:0] len);
      int unsigned dd;
      dd = (len > 1000) ? 1000 : len;
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return IDX_MIN;
               1: return IDX_MAX;
               2: return '1;
               default: return '0;
            endcase
         end
         2: return {1'b0, len} + $urandom_range(0, 4) - 2;
         3: return 32'd0 - {1'b0, len} + $urandom_range(0, 4) - 2;
         default: return $urandom_range(0, 2 * dd + 6) - dd - 3;
      endcase
   endfunction

   function automatic req_payload_type random_axis();
      req_payload_type p;
      p.axis_number = AXIS_WIDTH'($urandom_range(0, MAX_AXES - 1));
      p.infer_unknown = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: p.axis_length = LENGTH_WIDTH'($urandom);
         1: p.axis_length = $urandom_range(0, 1) ? '1 : '0;
         default: p.axis_length = LENGTH_WIDTH'($urandom_range(0, 64));
      endcase
      p.slice_start = pick_index(p.axis_length);
      p.slice_end = pick_index(p.axis_length);
      case ($urandom_range(0, 9))
         0: p.stride_value = '0;
         1: p.stride_value = $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: p.stride_value = IDX_MIN;
               1: p.stride_value = IDX_MAX;
               2: p.stride_value = -1;
               default: p.stride_value = 1;
            endcase
         end
         default: begin
            p.stride_value = $urandom_range(1, 5);
            if ($urandom_range(0, 1))
               p.stride_value = -p.stride_value;
         end
      endcase
      // Some requests take the dropped-axis form with whatever stride came up.
      if ($urandom_range(0, 7) == 0) begin
         p.slice_start = -1;
         p.slice_end = 0;
         p.infer_unknown = 1'b1;
      end
      return p;
   endfunction

   initial begin
      logic [MASK_WIDTH-1:0] phase_mask[4];
      int                    ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      idle_on = 1'b0;
      mask_settings = 0;
      phase_mask[0] = 8'h00;
      phase_mask[1] = 8'hFF;
      phase_mask[2] = MASK_WIDTH'($urandom);
      phase_mask[3] = MASK_WIDTH'($urandom);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      write_mask(DIRECTED_MASK);

      // Dropped axes: plain, zero stride, negative stride, empty axis, min stride.
      send_fields(0, 10, -1, 0, 1, 1'b1);
      send_fields(2, 10, -1, 0, 0, 1'b1);
      send_fields(7, 5, -1, 0, -3, 1'b1);
      send_fields(5, 0, -1, 0, IDX_MAX, 1'b1);
      send_fields(7, IDX_MAX, -1, 0, IDX_MIN, 1'b1);
      // Near misses of the dropped form: mask bit clear, flag clear, end not zero.
      send_fields(1, 10, -1, 0, 1, 1'b1);
      send_fields(0, 10, -1, 0, 1, 1'b0);
      send_fields(0, 10, -1, 1, 1, 1'b1);
      send_fields(3, 10, 3, 7, 0, 1'b0);
      send_fields(3, 10, -20, -30, 0, 1'b1);
      send_fields(4, 10, 7, 2, 1, 1'b0);
      send_fields(4, 10, 2, 7, -1, 1'b0);
      send_fields(6, 10, 1, 9, 3, 1'b0);
      send_fields(6, 10, 8, 1, -2, 1'b1);
      send_fields(1, 10, -3, -1, 1, 1'b0);
      send_fields(1, 10, 9, -1, -1, 1'b0);
      send_fields(2, 4, 10, 20, 1, 1'b0);
      send_fields(2, 6, IDX_MIN, IDX_MAX, 1, 1'b1);
      send_fields(3, 0, 0, 0, 1, 1'b0);
      send_fields(7, IDX_MAX, 0, IDX_MAX, 1, 1'b1);
      send_fields(7, IDX_MAX, IDX_MAX, IDX_MIN, IDX_MIN, 1'b0);
      send_fields(6, IDX_MAX, 0, IDX_MAX, IDX_MAX, 1'b1);
      send_fields(5, 100, IDX_MAX, IDX_MIN, -1, 1'b0);
      send_fields(4, 3, -2, IDX_MIN, -1, 1'b1);

      for (ph = 0; ph < 4; ph++) begin
         write_mask(phase_mask[ph]);
         // The final phase runs at full rate on both sides.
         idle_on = (ph != 3);
         repeat (PHASE_ITEMS) send_request(random_axis());
      end

      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Checked %0d responses under %0d mask values: %0d dropped axes,",
               sb.checked, mask_settings, sb.dropped);
      $display("%0d zero strides, %0d opposed ranges, %0d cycles with the input stalled.",
               sb.zero_strides, sb.opposed, input_stall_cycles);
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches found.", sb.mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
